// ----- design/sap_pkg.sv -----
// Shared widths, constants and types for the shape area and perimeter unit.
package sap_pkg;

  // Field widths
  localparam int OP_W      = 2;
  localparam int DIM_W     = 16;
  localparam int FRAC_BITS = 8;
  localparam int AREA_W    = 26;
  localparam int PERIM_W   = 19;

  // Pi in Q2.16
  localparam int            PI_W   = 18;
  localparam logic [PI_W-1:0] PI_Q16 = 18'd205887;

  // Internal widths
  localparam int SUM_W   = DIM_W + 2;          // a+b+c
  localparam int SQ_W    = 2 * DIM_W;          // r*r or w*h
  localparam int CPER_W  = DIM_W + PI_W;       // r*pi
  localparam int CAREA_W = SQ_W + PI_W;        // r*r*pi
  localparam int PROD_W  = 2 * SUM_W;          // s*(s-2a), (s-2b)*(s-2c)
  localparam int HALF_W  = PROD_W / 2;         // split of the wide multiply
  localparam int PP_W    = PROD_W + HALF_W;    // partial product
  localparam int RAD_W   = 2 * PROD_W;         // full Heron product
  localparam int ROOT_W  = RAD_W / 2;          // its square root
  localparam int REM_W   = ROOT_W + 3;         // root remainder

  // Scaling shifts
  localparam int PERIM_SHIFT = 15;
  localparam int CIRC_SHIFT  = 16 + FRAC_BITS;
  localparam int HERON_SHIFT = FRAC_BITS + 2;

  typedef enum logic [OP_W-1:0] {
    OP_CIRCLE = 2'd0,
    OP_RECT   = 2'd1,
    OP_TRI    = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  // Result fields that travel beside the triangle arithmetic
  typedef struct packed {
    op_t                kind;
    logic [AREA_W-1:0]  area;
    logic [PERIM_W-1:0] perim;
    logic               bad;
  } side_t;

  // Heron factor pair
  typedef struct packed {
    logic [PROD_W-1:0] p1;
    logic [PROD_W-1:0] p2;
  } prod_t;

endpackage

// ----- design/sap_prep.sv -----
// Front stages: sums, triangle terms, short products, circle and rectangle results.
module sap_prep (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        in_v,
  input  logic [sap_pkg::OP_W-1:0]    op,
  input  logic [sap_pkg::DIM_W-1:0]   dim_a,
  input  logic [sap_pkg::DIM_W-1:0]   dim_b,
  input  logic [sap_pkg::DIM_W-1:0]   dim_c,
  output logic                        out_v,
  output sap_pkg::prod_t              prod,
  output sap_pkg::side_t              side
);
  import sap_pkg::*;

  op_t                kind;
  logic [SUM_W-1:0]   s_next;
  logic [SUM_W-1:0]   ta;
  logic [SUM_W-1:0]   tb;
  logic [SUM_W-1:0]   tc;
  logic               bad_next;
  logic [DIM_W-1:0]   msel;
  logic [SQ_W-1:0]    sq_next;
  logic [CPER_W-1:0]  cper;
  logic [SUM_W-1:0]   rsum;
  logic [PERIM_W-1:0] perim_next;

  // stage 1 registers
  logic               v1;
  op_t                op1;
  logic [SUM_W-1:0]   s1;
  logic [SUM_W-1:0]   ea1;
  logic [SUM_W-1:0]   eb1;
  logic [SUM_W-1:0]   ec1;
  logic               bad1;
  logic [SQ_W-1:0]    sq1;
  logic [PERIM_W-1:0] perim1;

  logic [CAREA_W-1:0] carea;
  logic [AREA_W-1:0]  area_next;

  assign kind = op_t'(op);

  // Triangle sum and doubled sides
  assign s_next   = SUM_W'(dim_a) + SUM_W'(dim_b) + SUM_W'(dim_c);
  assign ta       = SUM_W'({dim_a, 1'b0});
  assign tb       = SUM_W'({dim_b, 1'b0});
  assign tc       = SUM_W'({dim_c, 1'b0});
  assign bad_next = (s_next <= ta) || (s_next <= tb) || (s_next <= tc);

  // Radius squared or width times height
  assign msel    = (kind == OP_CIRCLE) ? dim_a : dim_b;
  assign sq_next = SQ_W'(dim_a) * SQ_W'(msel);

  // Perimeter for every kind
  assign cper = CPER_W'(dim_a) * CPER_W'(PI_Q16);
  assign rsum = SUM_W'(dim_a) + SUM_W'(dim_b);

  always_comb begin
    case (kind)
      OP_CIRCLE: perim_next = cper[PERIM_SHIFT +: PERIM_W];
      OP_RECT:   perim_next = PERIM_W'({rsum, 1'b0});
      OP_TRI:    perim_next = PERIM_W'(s_next);
      default:   perim_next = '0;
    endcase
  end

  // Stage 1
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op1    <= kind;
      s1     <= s_next;
      ea1    <= s_next - ta;
      eb1    <= s_next - tb;
      ec1    <= s_next - tc;
      bad1   <= bad_next;
      sq1    <= sq_next;
      perim1 <= perim_next;
    end
  end

  // Circle and rectangle area
  assign carea = CAREA_W'(sq1) * CAREA_W'(PI_Q16);

  always_comb begin
    case (op1)
      OP_CIRCLE: area_next = carea[CIRC_SHIFT +: AREA_W];
      OP_RECT:   area_next = AREA_W'(sq1[SQ_W-1:FRAC_BITS]);
      default:   area_next = '0;
    endcase
  end

  // Stage 2
  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (en) begin
      out_v <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod.p1    <= PROD_W'(s1) * PROD_W'(ea1);
      prod.p2    <= PROD_W'(eb1) * PROD_W'(ec1);
      side.kind  <= op1;
      side.area  <= area_next;
      side.perim <= perim1;
      side.bad   <= (op1 == OP_TRI) && bad1;
    end
  end

endmodule

// ----- design/sap_wmul.sv -----
// Wide Heron product, formed from two registered partial products.
module sap_wmul (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        in_v,
  input  sap_pkg::prod_t              prod,
  input  sap_pkg::side_t              in_side,
  output logic                        out_v,
  output logic [sap_pkg::RAD_W-1:0]   rad,
  output sap_pkg::side_t              out_side
);
  import sap_pkg::*;

  logic              v3;
  logic [PP_W-1:0]   pp_lo;
  logic [PP_W-1:0]   pp_hi;
  side_t             side3;

  // Partial products on the two halves of the second factor
  always_ff @(posedge clk) begin
    if (rst) begin
      v3    <= 1'b0;
      out_v <= 1'b0;
    end else if (en) begin
      v3    <= in_v;
      out_v <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pp_lo    <= PP_W'(prod.p1) * PP_W'(prod.p2[HALF_W-1:0]);
      pp_hi    <= PP_W'(prod.p1) * PP_W'(prod.p2[PROD_W-1:HALF_W]);
      side3    <= in_side;
      // combine the halves
      rad      <= RAD_W'(pp_lo) + {pp_hi, {HALF_W{1'b0}}};
      out_side <= side3;
    end
  end

endmodule

// ----- design/sap_isqrt.sv -----
// Integer square root, one root bit per pipeline stage.
module sap_isqrt (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        in_v,
  input  logic [sap_pkg::RAD_W-1:0]   rad,
  input  sap_pkg::side_t              in_side,
  output logic                        out_v,
  output logic [sap_pkg::ROOT_W-1:0]  root,
  output sap_pkg::side_t              out_side
);
  import sap_pkg::*;

  typedef struct packed {
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
    logic [RAD_W-1:0]  x;
  } sq_t;

  logic  vld [ROOT_W];
  sq_t   st  [ROOT_W];
  side_t sd  [ROOT_W];

  genvar i;
  generate
    for (i = 0; i < ROOT_W; i++) begin : g_stage
      logic             pv;
      sq_t              prev;
      side_t            ps;
      logic [REM_W-1:0] rem_sh;
      logic [REM_W-1:0] trial;
      logic             ge;

      if (i == 0) begin : g_first
        assign pv   = in_v;
        assign prev = '{rem: '0, root: '0, x: rad};
        assign ps   = in_side;
      end else begin : g_rest
        assign pv   = vld[i-1];
        assign prev = st[i-1];
        assign ps   = sd[i-1];
      end

      // bring down the next two radicand bits and try a one
      assign rem_sh = {prev.rem[REM_W-3:0], prev.x[RAD_W-1 -: 2]};
      assign trial  = REM_W'({prev.root, 2'b01});
      assign ge     = (rem_sh >= trial);

      always_ff @(posedge clk) begin
        if (rst) begin
          vld[i] <= 1'b0;
        end else if (en) begin
          vld[i] <= pv;
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          st[i].rem  <= ge ? (rem_sh - trial) : rem_sh;
          st[i].root <= {prev.root[ROOT_W-2:0], ge};
          st[i].x    <= {prev.x[RAD_W-3:0], 2'b00};
          sd[i]      <= ps;
        end
      end
    end
  endgenerate

  assign out_v    = vld[ROOT_W-1];
  assign root     = st[ROOT_W-1].root;
  assign out_side = sd[ROOT_W-1];

endmodule

// ----- design/sap_skid.sv -----
// Final result select, output register and skid stage.
module sap_skid (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_v,
  input  logic [sap_pkg::ROOT_W-1:0]    root,
  input  sap_pkg::side_t                in_side,
  output logic                          adv,
  output logic                          rsp_valid,
  input  logic                          rsp_ready,
  output logic [sap_pkg::AREA_W-1:0]    area,
  output logic [sap_pkg::PERIM_W-1:0]   perimeter,
  output logic                          invalid_triangle
);
  import sap_pkg::*;

  typedef struct packed {
    logic [AREA_W-1:0]  area;
    logic [PERIM_W-1:0] perim;
    logic               bad;
  } res_t;

  res_t res;
  res_t outr;
  res_t skr;
  logic sk_v;
  logic take;

  // Triangle area from the root, other kinds already done
  always_comb begin
    res.perim = in_side.perim;
    res.bad   = in_side.bad;
    if (in_side.kind == OP_TRI) begin
      res.area = in_side.bad ? '0 : root[HERON_SHIFT +: AREA_W];
    end else begin
      res.area = in_side.area;
    end
  end

  // Pipeline advances while the skid stage is empty
  assign adv  = !sk_v;
  assign take = !rsp_valid || rsp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
      sk_v      <= 1'b0;
    end else if (take) begin
      rsp_valid <= sk_v || in_v;
      sk_v      <= 1'b0;
    end else if (in_v && adv) begin
      sk_v      <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      outr <= sk_v ? skr : res;
    end
    if (!take && adv) begin
      skr <= res;
    end
  end

  assign area             = outr.area;
  assign perimeter        = outr.perim;
  assign invalid_triangle = outr.bad;

endmodule

// ----- design/shape_area_perimeter_unit.sv -----
// Top level of the shape area and perimeter unit.
// Takes one shape query per cycle while req_ready is high (circle, rectangle
// or triangle with Q8.8 dimensions) and returns its Q.8 area and perimeter,
// rounded down, plus a flag for a degenerate triangle. A transfer on the
// request channel passes through two front stages, two stages for the wide
// Heron product, 36 stages of the square root (one root bit per stage) and
// the output register on its way to the response channel. While the skid
// stage is empty, throughput is one item per cycle. An output register plus a
// skid stage sit at the end, so req_ready is registered: while the response
// side stalls, requests are still taken until a result reaches the stalled
// output and moves into the skid stage (one more request when the pipeline is
// full); req_ready then drops until the skid stage drains.
module shape_area_perimeter_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          req_valid,
  output logic                          req_ready,
  input  logic [sap_pkg::OP_W-1:0]      op,
  input  logic [sap_pkg::DIM_W-1:0]     dim_a,
  input  logic [sap_pkg::DIM_W-1:0]     dim_b,
  input  logic [sap_pkg::DIM_W-1:0]     dim_c,
  output logic                          rsp_valid,
  input  logic                          rsp_ready,
  output logic [sap_pkg::AREA_W-1:0]    area,
  output logic [sap_pkg::PERIM_W-1:0]   perimeter,
  output logic                          invalid_triangle
);
  import sap_pkg::*;

  logic              adv;
  logic              v2;
  prod_t             prod2;
  side_t             side2;
  logic              v4;
  logic [RAD_W-1:0]  rad4;
  side_t             side4;
  logic              vr;
  logic [ROOT_W-1:0] root;
  side_t             sider;

  assign req_ready = adv;

  sap_prep u_prep (
    .clk   (clk),
    .rst   (rst),
    .en    (adv),
    .in_v  (req_valid),
    .op    (op),
    .dim_a (dim_a),
    .dim_b (dim_b),
    .dim_c (dim_c),
    .out_v (v2),
    .prod  (prod2),
    .side  (side2)
  );

  sap_wmul u_wmul (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .in_v     (v2),
    .prod     (prod2),
    .in_side  (side2),
    .out_v    (v4),
    .rad      (rad4),
    .out_side (side4)
  );

  sap_isqrt u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .in_v     (v4),
    .rad      (rad4),
    .in_side  (side4),
    .out_v    (vr),
    .root     (root),
    .out_side (sider)
  );

  sap_skid u_skid (
    .clk              (clk),
    .rst              (rst),
    .in_v             (vr),
    .root             (root),
    .in_side          (sider),
    .adv              (adv),
    .rsp_valid        (rsp_valid),
    .rsp_ready        (rsp_ready),
    .area             (area),
    .perimeter        (perimeter),
    .invalid_triangle (invalid_triangle)
  );

endmodule

// ----- design/sap_checker.sv -----
// Port-level checks for the shape area and perimeter unit, bound to the top level.
module sap_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          req_valid,
  input logic                          req_ready,
  input logic [sap_pkg::OP_W-1:0]      op,
  input logic [sap_pkg::DIM_W-1:0]     dim_a,
  input logic [sap_pkg::DIM_W-1:0]     dim_b,
  input logic [sap_pkg::DIM_W-1:0]     dim_c,
  input logic                          rsp_valid,
  input logic                          rsp_ready,
  input logic [sap_pkg::AREA_W-1:0]    area,
  input logic [sap_pkg::PERIM_W-1:0]   perimeter,
  input logic                          invalid_triangle
);
  import sap_pkg::*;

  // Hold a waiting request
  a_req_hold: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_ready |=> req_valid && $stable(op) && $stable(dim_a)
      && $stable(dim_b) && $stable(dim_c))
    else $error("request changed while waiting");

  // Hold a stalled response
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(area) && $stable(perimeter)
      && $stable(invalid_triangle))
    else $error("response changed while stalled");

  // A degenerate triangle has no area
  a_bad_area: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && invalid_triangle |-> area == '0)
    else $error("invalid triangle with non-zero area");

  // Backpressure only follows a stalled response
  a_ready_fall: assert property (@(posedge clk) disable iff (rst)
    $fell(req_ready) |-> $past(rsp_valid && !rsp_ready))
    else $error("request side stalled without a stalled response");

  // With the output empty the request side is open
  a_ready_empty: assert property (@(posedge clk) disable iff (rst)
    !rsp_valid |-> req_ready)
    else $error("request side stalled with an empty output");

endmodule

bind shape_area_perimeter_unit sap_checker u_sap_checker (
  .clk              (clk),
  .rst              (rst),
  .req_valid        (req_valid),
  .req_ready        (req_ready),
  .op               (op),
  .dim_a            (dim_a),
  .dim_b            (dim_b),
  .dim_c            (dim_c),
  .rsp_valid        (rsp_valid),
  .rsp_ready        (rsp_ready),
  .area             (area),
  .perimeter        (perimeter),
  .invalid_triangle (invalid_triangle)
);

// ----- tb/sv/shape_area_perimeter_unit_tb.sv -----
// Testbench for the shape area and perimeter unit: queued queries, prediction and checks.
module shape_area_perimeter_unit_tb;
  import sap_pkg::*;

  // Arithmetic constants of the geometry, kept apart from the design's own
  localparam logic [63:0] PI_SCALED  = 64'd205887;   // pi * 2^16
  localparam int          R2_SPLIT   = 16 + 8;       // pi scale plus fraction bits
  localparam int          RECT_DROP  = 8;
  localparam int          CPER_DROP  = 15;
  localparam int          HERON_DROP = 8 + 2;
  localparam logic [63:0] AREA_TOP   = (64'd1 << AREA_W) - 1;
  localparam logic [63:0] PERIM_TOP  = (64'd1 << PERIM_W) - 1;
  localparam int          DIM_TOP    = (1 << DIM_W) - 1;
  localparam int          DRAIN_CYC  = 80;
  localparam int          LIMIT_CYC  = 200000;

  typedef struct {
    op_t              kind;
    logic [DIM_W-1:0] a;
    logic [DIM_W-1:0] b;
    logic [DIM_W-1:0] c;
  } shape_query_t;

  typedef struct {
    logic [AREA_W-1:0]  area;
    logic [PERIM_W-1:0] perim;
    logic               bad;
  } shape_answer_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                req_valid = 1'b0;
  logic                req_ready;
  logic [OP_W-1:0]     op = '0;
  logic [DIM_W-1:0]    dim_a = '0;
  logic [DIM_W-1:0]    dim_b = '0;
  logic [DIM_W-1:0]    dim_c = '0;
  logic                rsp_valid;
  logic                rsp_ready = 1'b0;
  logic [AREA_W-1:0]   area;
  logic [PERIM_W-1:0]  perimeter;
  logic                invalid_triangle;

  shape_query_t  query_q[$];
  shape_answer_t answer_q[$];
  shape_query_t  next_query;
  shape_answer_t want_ans;
  int            send_idle = 33;
  int            recv_idle = 63;
  int            mismatches = 0;

  shape_area_perimeter_unit u_top (
    .clk              (clk),
    .rst              (rst),
    .req_valid        (req_valid),
    .req_ready        (req_ready),
    .op               (op),
    .dim_a            (dim_a),
    .dim_b            (dim_b),
    .dim_c            (dim_c),
    .rsp_valid        (rsp_valid),
    .rsp_ready        (rsp_ready),
    .area             (area),
    .perimeter        (perimeter),
    .invalid_triangle (invalid_triangle)
  );

  always #10 clk = ~clk;

  // Work out area, perimeter and the degenerate flag of one query
  function automatic shape_answer_t predict_shape(logic [OP_W-1:0] kind,
                                                  logic [DIM_W-1:0] da,
                                                  logic [DIM_W-1:0] db,
                                                  logic [DIM_W-1:0] dc);
    logic [63:0]   a, b, c, s, r2, p1, p2, root, cand, area_full, perim_full;
    logic [127:0]  prod, sq;
    shape_answer_t res;
    a = 64'(da);
    b = 64'(db);
    c = 64'(dc);
    area_full  = '0;
    perim_full = '0;
    res.bad    = 1'b0;
    case (kind)
      OP_CIRCLE: begin
        r2 = a * a;
        area_full = (r2 >> R2_SPLIT) * PI_SCALED
                  + (((r2 & ((64'd1 << R2_SPLIT) - 1)) * PI_SCALED) >> R2_SPLIT);
        perim_full = (a * PI_SCALED) >> CPER_DROP;
      end
      OP_RECT: begin
        area_full  = (a * b) >> RECT_DROP;
        perim_full = 64'd2 * (a + b);
      end
      OP_TRI: begin
        s = a + b + c;
        perim_full = s;
        if (s <= 64'd2 * a || s <= 64'd2 * b || s <= 64'd2 * c) begin
          res.bad = 1'b1;
        end else begin
          p1   = s * (s - 64'd2 * a);
          p2   = (s - 64'd2 * b) * (s - 64'd2 * c);
          prod = {64'd0, p1} * {64'd0, p2};
          // Exact floor square root, one bit at a time from the top
          root = '0;
          for (int i = 63; i >= 0; i--) begin
            cand = root | (64'd1 << i);
            sq   = {64'd0, cand} * {64'd0, cand};
            if (sq <= prod) root = cand;
          end
          area_full = root >> HERON_DROP;
        end
      end
      default: ;
    endcase
    res.area  = (area_full > AREA_TOP) ? AREA_TOP[AREA_W-1:0] : area_full[AREA_W-1:0];
    res.perim = (perim_full > PERIM_TOP) ? PERIM_TOP[PERIM_W-1:0] : perim_full[PERIM_W-1:0];
    return res;
  endfunction

  task automatic add_query(op_t kind, int a, int b, int c);
    shape_query_t q;
    q.kind = kind;
    q.a    = a[DIM_W-1:0];
    q.b    = b[DIM_W-1:0];
    q.c    = c[DIM_W-1:0];
    query_q.push_back(q);
  endtask

  // Queue random queries: mostly real shapes, well-formed triangles dominating the triangle queries
  task automatic add_random(int count);
    op_t kind;
    int  a, b, c, lo, hi, mode;
    for (int n = 0; n < count; n++) begin
      kind = ($urandom_range(99) < 5) ? OP_NONE : op_t'($urandom_range(2));
      mode = $urandom_range(3);
      a = $urandom_range(DIM_TOP);
      b = $urandom_range(DIM_TOP);
      c = $urandom_range(DIM_TOP);
      if (mode == 1) begin
        a = $urandom_range(1023);
        b = $urandom_range(1023);
        c = $urandom_range(1023);
      end else if (mode == 2) begin
        a = DIM_TOP - $urandom_range(255);
        b = DIM_TOP - $urandom_range(255);
        c = DIM_TOP - $urandom_range(255);
      end
      if (kind == OP_TRI && $urandom_range(3) != 0) begin
        lo = (a > b) ? a - b : b - a;
        hi = (a + b > DIM_TOP) ? DIM_TOP : a + b;
        c  = $urandom_range(hi, lo);
        // push some onto the flat edge
        if ($urandom_range(9) == 0) c = ($urandom_range(1) != 0) ? lo : hi;
      end
      add_query(kind, a, b, c);
    end
  endtask

  task automatic report_mismatch(string what, shape_answer_t want);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t %s: want area=%0d perim=%0d bad=%0d, got area=%0d perim=%0d bad=%0d",
               $time, what, want.area, want.perim, want.bad,
               area, perimeter, invalid_triangle);
  endtask

  // Present queued queries; hold the payload until the transfer completes
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (!req_valid || req_ready) begin
      if (query_q.size() != 0 && $urandom_range(99) >= send_idle) begin
        next_query = query_q.pop_front();
        req_valid <= 1'b1;
        op        <= next_query.kind;
        dim_a     <= next_query.a;
        dim_b     <= next_query.b;
        dim_c     <= next_query.c;
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  // Stall the response side at random
  always @(posedge clk) begin
    if (rst) begin
      rsp_ready <= 1'b0;
    end else begin
      rsp_ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // Check each response transfer, then record the prediction for a new request
  always @(posedge clk) begin
    if (!rst) begin
      if (rsp_valid && rsp_ready) begin
        if (answer_q.size() == 0) begin
          want_ans = '{area: '0, perim: '0, bad: 1'b0};
          report_mismatch("response with nothing pending", want_ans);
        end else begin
          want_ans = answer_q.pop_front();
          if (area !== want_ans.area || perimeter !== want_ans.perim ||
              invalid_triangle !== want_ans.bad)
            report_mismatch("result mismatch", want_ans);
        end
      end
      if (req_valid && req_ready)
        answer_q.push_back(predict_shape(op, dim_a, dim_b, dim_c));
    end
  end

  initial begin
    // Corners: zero and full-scale dimensions, unit values, every kind
    add_query(OP_CIRCLE, 0, 0, 0);
    add_query(OP_CIRCLE, DIM_TOP, DIM_TOP, DIM_TOP);
    add_query(OP_CIRCLE, 256, 12345, 54321);
    add_query(OP_RECT, 0, 0, 0);
    add_query(OP_RECT, DIM_TOP, DIM_TOP, DIM_TOP);
    add_query(OP_RECT, DIM_TOP, 0, 777);
    add_query(OP_RECT, 256, 256, 0);
    add_query(OP_RECT, 1, DIM_TOP, 0);
    add_query(OP_TRI, DIM_TOP, DIM_TOP, DIM_TOP);
    add_query(OP_TRI, 768, 1024, 1280);
    add_query(OP_TRI, 256, 512, 768);
    add_query(OP_TRI, 0, 256, 256);
    add_query(OP_TRI, 100, 100, DIM_TOP);
    add_query(OP_TRI, 0, 0, 0);
    add_query(OP_TRI, 1, 1, 1);
    add_query(OP_TRI, DIM_TOP, DIM_TOP, 1);
    add_query(OP_TRI, 32768, 32767, DIM_TOP);
    add_query(OP_NONE, 1234, 5678, 9012);
    add_query(OP_NONE, DIM_TOP, DIM_TOP, DIM_TOP);
    add_query(OP_NONE, 0, 0, 0);
    add_random(650);

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Sender busy, receiver mostly stalled; then swapped; then no idling
    while (query_q.size() != 0) @(posedge clk);
    send_idle = 63;
    recv_idle = 33;
    add_random(670);
    while (query_q.size() != 0) @(posedge clk);
    send_idle = 0;
    recv_idle = 0;
    add_random(670);
    while (query_q.size() != 0 || req_valid) @(posedge clk);

    while (answer_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Give up if the run hangs
  initial begin
    #(20 * LIMIT_CYC);
    $display("DONE: errors detected");
    $finish;
  end

endmodule

// ----- shape_area_perimeter_unit.f -----
design/sap_pkg.sv
design/sap_prep.sv
design/sap_wmul.sv
design/sap_isqrt.sv
design/sap_skid.sv
design/shape_area_perimeter_unit.sv
design/sap_checker.sv
tb/sv/shape_area_perimeter_unit_tb.sv
